// ===== rtl/sssc_pkg.sv =====
package sssc_pkg;

   localparam int STORE_DEPTH   = 64;
   localparam int VALUE_WIDTH   = 32;
   localparam int PERCENT_SCALE = 100;

   localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int NUM_W  = $clog2(STORE_DEPTH * PERCENT_SCALE + 1);
   localparam int STEP_W = $clog2(NUM_W + 1);

   localparam int MODE_FIELD_W   = 2;
   localparam int VALUE_FIELD_W  = 32;
   localparam int STATUS_FIELD_W = 2;
   localparam int COUNT_FIELD_W  = 7;
   localparam int PCT_FIELD_W    = 7;

   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [NUM_W-1:0]         num_type;
   typedef logic [STEP_W-1:0]        step_type;
   typedef logic [VALUE_WIDTH-1:0]   value_type;
   typedef logic [IDX_W+1:0]         ring_sum_type;
   typedef logic [COUNT_FIELD_W-1:0] count_field_type;
   typedef logic [PCT_FIELD_W-1:0]   pct_field_type;

   typedef enum logic [MODE_FIELD_W-1:0] {
      MODE_FRONT   = 2'd0,
      MODE_BACK    = 2'd1,
      MODE_SEARCH  = 2'd2,
      MODE_PERCENT = 2'd3
   } mode_type;

   typedef enum logic [STATUS_FIELD_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Ring position of base plus offset, wrapping at the store depth.
   function automatic idx_type ring_add(idx_type base, cnt_type offset);
      ring_sum_type sum;
      sum = ring_sum_type'(base) + ring_sum_type'(offset);
      if (sum >= ring_sum_type'(STORE_DEPTH)) begin
         sum = sum - ring_sum_type'(STORE_DEPTH);
      end
      return idx_type'(sum);
   endfunction

endpackage

// ===== rtl/sssc_req_if.sv =====
interface sssc_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [sssc_pkg::MODE_FIELD_W-1:0]        mode;
   logic signed [sssc_pkg::VALUE_FIELD_W-1:0] value;

   modport source (output valid, mode, value, input ready);
   modport sink   (input valid, mode, value, output ready);
endinterface

// ===== rtl/sssc_rsp_if.sv =====
interface sssc_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [sssc_pkg::STATUS_FIELD_W-1:0]   status;
   logic                                  found;
   logic [sssc_pkg::COUNT_FIELD_W-1:0]    match_count;
   logic [sssc_pkg::PCT_FIELD_W-1:0]      percent;
   logic [sssc_pkg::COUNT_FIELD_W-1:0]    entry_total;

   modport source (output valid, status, found, match_count, percent, entry_total,
                   input ready);
   modport sink   (input valid, status, found, match_count, percent, entry_total,
                   output ready);
endinterface

// ===== rtl/sssc_ram.sv =====
module sssc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sssc_div.sv =====
module sssc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  sssc_pkg::num_type dividend,
   input  sssc_pkg::cnt_type divisor,
   output logic              done,
   output sssc_pkg::num_type quotient
);

   typedef logic [sssc_pkg::CNT_W:0] trial_type;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   sssc_pkg::step_type step_ff, step_in;
   sssc_pkg::cnt_type  rem_ff, rem_in;
   sssc_pkg::num_type  quo_ff, quo_in;
   sssc_pkg::cnt_type  dsr_ff, dsr_in;
   trial_type          shifted;
   logic               fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      shifted = {rem_ff, quo_ff[sssc_pkg::NUM_W-1]};
      fits    = (shifted >= trial_type'(dsr_ff));
      if (start) begin
         busy_in = 1'b1;
         step_in = sssc_pkg::step_type'(sssc_pkg::NUM_W);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = sssc_pkg::cnt_type'(shifted - trial_type'(dsr_ff));
         end else begin
            rem_in = sssc_pkg::cnt_type'(shifted);
         end
         quo_in  = {quo_ff[sssc_pkg::NUM_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == sssc_pkg::step_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/sequence_store_search_count.sv =====
// Channel   Direction  Beat contents
// req_bus   in         mode, value
// rsp_bus   out        status, found, match_count, percent, entry_total
//
// An add, a refused add or a query on an empty store goes straight to the finish
// state, which loads the result once the result register is free. A search first
// scans the entries; a percentage query then runs the bit-serial divider as well.
// The scan reads one entry a cycle through the single read port of the store.
// Reset clears the state, the head pointer, the entry count and the result valid flag.
// One request is in flight at a time; a finished result waits in its register
// until taken, while the block is already free for the next request.
module sequence_store_search_count (
   input  logic       clock,
   input  logic       reset,
   sssc_req_if.sink   req_bus,
   sssc_rsp_if.source rsp_bus
);

   sssc_pkg::state_type  state_ff, state_in;
   sssc_pkg::idx_type    head_ff, head_in;
   sssc_pkg::cnt_type    count_ff, count_in;
   sssc_pkg::mode_type   mode_ff, mode_in;
   sssc_pkg::value_type  value_ff, value_in;
   sssc_pkg::status_type res_status_ff, res_status_in;
   sssc_pkg::cnt_type    issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   sssc_pkg::cnt_type    match_ff, match_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [sssc_pkg::STATUS_FIELD_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                                  rsp_found_ff, rsp_found_in;
   sssc_pkg::count_field_type             rsp_match_ff, rsp_match_in;
   sssc_pkg::pct_field_type               rsp_pct_ff, rsp_pct_in;
   sssc_pkg::count_field_type             rsp_total_ff, rsp_total_in;

   logic                 wr_en;
   sssc_pkg::idx_type    wr_addr;
   logic                 rd_en;
   sssc_pkg::idx_type    rd_addr;
   sssc_pkg::value_type  rd_data;
   logic                 div_start;
   logic                 div_done;
   sssc_pkg::num_type    div_dividend;
   sssc_pkg::num_type    div_quotient;
   sssc_pkg::mode_type   req_mode;
   sssc_pkg::value_type  req_value;
   logic                 req_take;

   assign req_mode  = sssc_pkg::mode_type'(req_bus.mode);
   assign req_value = sssc_pkg::value_type'(req_bus.value);
   assign req_take  = req_bus.valid && req_bus.ready;

   sssc_ram #(
      .WIDTH (sssc_pkg::VALUE_WIDTH),
      .DEPTH (sssc_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign div_dividend = sssc_pkg::num_type'(match_ff)
                         * sssc_pkg::num_type'(sssc_pkg::PERCENT_SCALE);

   sssc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      res_status_in = res_status_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      match_in      = match_ff;
      wr_en         = 1'b0;
      wr_addr       = sssc_pkg::ring_add(head_ff, count_ff);
      rd_en         = 1'b0;
      rd_addr       = sssc_pkg::ring_add(head_ff, issue_ff);
      div_start     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_pct_in    = rsp_pct_ff;
      rsp_total_in  = rsp_total_ff;
      req_bus.ready = (state_ff == sssc_pkg::ST_IDLE);

      case (state_ff)
         sssc_pkg::ST_IDLE: begin
            if (req_take) begin
               mode_in       = req_mode;
               value_in      = req_value;
               res_status_in = sssc_pkg::STATUS_DONE;
               issue_in      = '0;
               match_in      = '0;
               state_in      = sssc_pkg::ST_FINISH;
               if (req_mode == sssc_pkg::MODE_FRONT || req_mode == sssc_pkg::MODE_BACK) begin
                  if (count_ff == sssc_pkg::cnt_type'(sssc_pkg::STORE_DEPTH)) begin
                     res_status_in = sssc_pkg::STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     if (req_mode == sssc_pkg::MODE_FRONT) begin
                        head_in = sssc_pkg::ring_add(head_ff,
                                     sssc_pkg::cnt_type'(sssc_pkg::STORE_DEPTH - 1));
                        wr_addr = head_in;
                     end
                  end
               end else if (count_ff == '0) begin
                  res_status_in = sssc_pkg::STATUS_EMPTY;
               end else begin
                  state_in = sssc_pkg::ST_SCAN;
               end
            end
         end
         sssc_pkg::ST_SCAN: begin
            rd_en = (issue_ff < count_ff);
            if (rd_en) begin
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
            end
            if (pend_ff && rd_data == value_ff) begin
               match_in = match_ff + 1'b1;
            end
            if (!rd_en && !pend_ff) begin
               if (mode_ff == sssc_pkg::MODE_PERCENT) begin
                  div_start = 1'b1;
                  state_in  = sssc_pkg::ST_DIVIDE;
               end else begin
                  state_in = sssc_pkg::ST_FINISH;
               end
            end
         end
         sssc_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = sssc_pkg::ST_FINISH;
            end
         end
         sssc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = 1'b0;
               rsp_match_in  = '0;
               rsp_pct_in    = '0;
               rsp_total_in  = sssc_pkg::count_field_type'(count_ff);
               if (res_status_ff == sssc_pkg::STATUS_DONE) begin
                  if (mode_ff == sssc_pkg::MODE_SEARCH) begin
                     rsp_found_in = (match_ff != '0);
                  end else if (mode_ff == sssc_pkg::MODE_PERCENT) begin
                     rsp_match_in = sssc_pkg::count_field_type'(match_ff);
                     rsp_pct_in   = sssc_pkg::pct_field_type'(div_quotient);
                  end
               end
               state_in = sssc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sssc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sssc_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      res_status_ff <= res_status_in;
      issue_ff      <= issue_in;
      match_ff      <= match_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_pct_ff    <= rsp_pct_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.found       = rsp_found_ff;
   assign rsp_bus.match_count = rsp_match_ff;
   assign rsp_bus.percent     = rsp_pct_ff;
   assign rsp_bus.entry_total = rsp_total_ff;

   // The entry count never passes the depth of the store.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= sssc_pkg::cnt_type'(sssc_pkg::STORE_DEPTH))
      else $error("entry count above store depth");

   // A scan is only entered with live entries.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sssc_pkg::ST_SCAN) |-> (count_ff != '0))
      else $error("scan on an empty store");

   // The divider finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == sssc_pkg::ST_DIVIDE))
      else $error("divider result outside divide phase");

   // The ring pointers change only on an accepted request.
   assert property (@(posedge clock) disable iff (reset)
      !req_take |=> ($stable(head_ff) && $stable(count_ff)))
      else $error("ring state changed without a request");

   // Matches never exceed the entries scanned so far.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sssc_pkg::ST_SCAN) |-> (match_ff <= issue_ff))
      else $error("match count ahead of scan");

endmodule
